// ===== rtl/core/sbcd_pkg.sv =====
// Shared types, constants and codes for the signed BCD add, subtract and multiply unit.
package sbcd_pkg;

	// Port field widths fixed by the interface.
	localparam int FIELD_W    = 64;
	localparam int NIB_W      = 4;
	localparam int DIGITS_MAX = 16;
	localparam int DIGITS_DEF = 16;

	// Column value and carry widths, sized for the largest digit count.
	// A multiply column holds at most DIGITS_MAX * 15 * 15 = 3600 and the
	// carry into a column stays at or below 400, so the sum fits 13 signed bits.
	localparam int COL_W   = 13;
	localparam int CARRY_W = 10;

	// Floor division by ten after offsetting the value to be nonnegative.
	// The reciprocal product is exact for offset values below 16379.
	localparam int DIV_OFFSET = 20;
	localparam int DIV_RECIP  = 6554;
	localparam int DIV_SHIFT  = 16;

	// Command codes. Bit one selects multiply, so the last code multiplies too.
	localparam logic [1:0] CMD_ADD     = 2'd0;
	localparam logic [1:0] CMD_SUB     = 2'd1;
	localparam logic [1:0] CMD_MUL     = 2'd2;
	localparam logic [1:0] CMD_MUL_ALT = 2'd3;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_NEG,
		ST_DONE
	} state_t;

	// Effective operation once the signs have been folded in.
	typedef enum logic [1:0] {
		MODE_ADD,
		MODE_SUB,
		MODE_MUL
	} mode_t;

	// Output of the shared digit unit.
	typedef struct packed {
		logic [NIB_W-1:0]          digit;
		logic signed [CARRY_W-1:0] carry;
	} dig_res_t;

endpackage

// ===== rtl/core/sbcd_digit_unit.sv =====
// Shared digit unit: reduces a column value plus carry to one decimal digit and a new carry.
module sbcd_digit_unit (
	input  logic signed [sbcd_pkg::COL_W-1:0]   col,
	input  logic signed [sbcd_pkg::CARRY_W-1:0] carry_in,
	output sbcd_pkg::dig_res_t                  res
);
	import sbcd_pkg::*;

	localparam logic signed [COL_W-1:0] OFFS = COL_W'(DIV_OFFSET);
	localparam logic [CARRY_W-1:0] CARRY_BIAS = CARRY_W'(DIV_OFFSET / 10);

	logic signed [COL_W-1:0] total;
	logic [COL_W-1:0]        biased;
	logic [2*COL_W-1:0]      prod;
	logic [CARRY_W-1:0]      quot;
	logic [COL_W-1:0]        rem;

	// Add the incoming carry and shift the value into the nonnegative range.
	always_comb begin
		total  = col + COL_W'(carry_in);
		biased = $unsigned(total + OFFS);
	end

	// Divide by ten through the reciprocal, then recover the remainder.
	always_comb begin
		prod = (2*COL_W)'(biased) * (2*COL_W)'(DIV_RECIP);
		quot = prod[DIV_SHIFT +: CARRY_W];
		rem  = biased - ((COL_W'(quot) << 3) + (COL_W'(quot) << 1));
	end

	// The bias of twenty equals two tens, so the carry loses two.
	always_comb begin
		res.digit = rem[NIB_W-1:0];
		res.carry = $signed(quot - CARRY_BIAS);
	end

endmodule

// ===== rtl/core/sbcd_mul_column.sv =====
// Multiply column: sums the digit products of one product column across all lanes.
module sbcd_mul_column #(
	parameter int DIGITS = sbcd_pkg::DIGITS_DEF
) (
	input  logic [sbcd_pkg::NIB_W*DIGITS-1:0] a_mag,
	input  logic [sbcd_pkg::NIB_W*DIGITS-1:0] lane_digits,
	output logic [sbcd_pkg::COL_W-2:0]        col_sum
);
	import sbcd_pkg::*;

	// Each lane pairs one digit of the first operand with the matching
	// digit of the second, so the lanes together cover one column.
	always_comb begin
		logic [COL_W-2:0] acc;
		acc = '0;
		for (int i = 0; i < DIGITS; i++) begin
			acc = acc + (COL_W-1)'(a_mag[NIB_W*i +: NIB_W])
				* (COL_W-1)'(lane_digits[NIB_W*i +: NIB_W]);
		end
		col_sum = acc;
	end

endmodule

// ===== rtl/core/signed_bcd_add_sub_mul.sv =====
// Top level of the signed BCD add, subtract and multiply unit with its sequencer.
//
// Usage: drive cmd, the two magnitudes and the two signs, and raise start.
// The transaction is accepted at a rising edge where start is high and busy
// is low. The block then works one decimal column per cycle through a single
// shared digit unit (column value plus carry, divide by ten). Each column of
// a product is formed by a row of digit multipliers over lanes that hold the
// second operand's digits in reverse order.
// After acceptance, done is high for exactly one cycle with result_digits,
// result_negative and overflow; the results are valid only in that cycle.
// Sequence: done rises once the run pass over the digit columns ends, and
// the result is taken at the edge that ends the done cycle. A subtraction
// whose difference turns out negative takes a second pass over the digits
// to form the ten's complement before done rises.
// Back to back: a new transaction may be accepted in the cycle where done
// is high, but not while busy is high during either pass.
// The receiver cannot stall; the next transaction overwrites the results.
// Reset returns the sequencer to idle and drops any transaction at work.
module signed_bcd_add_sub_mul #(
	parameter int DIGITS = sbcd_pkg::DIGITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   cmd,
	input  logic [sbcd_pkg::FIELD_W-1:0] a_digits,
	input  logic                         a_negative,
	input  logic [sbcd_pkg::FIELD_W-1:0] b_digits,
	input  logic                         b_negative,
	output logic                         done,
	output logic [sbcd_pkg::FIELD_W-1:0] result_digits,
	output logic                         result_negative,
	output logic                         overflow
);
	import sbcd_pkg::*;

	localparam int MAG_W = NIB_W * DIGITS;
	localparam int CNT_W = $clog2(DIGITS + 1);
	localparam logic [CNT_W-1:0] CNT_LAST_RUN = CNT_W'(DIGITS);
	localparam logic [CNT_W-1:0] CNT_LAST_NEG = CNT_W'(DIGITS - 1);
	localparam logic signed [CARRY_W-1:0] CARRY_MINUS2 = -CARRY_W'(2);

	state_t state_q, state_d;
	mode_t  mode_q, mode_d;

	logic [CNT_W-1:0]          cnt_q;
	logic [MAG_W-1:0]          a_q, b_q, res_q;
	logic [MAG_W-NIB_W-1:0]    lanes_q;
	logic signed [COL_W-1:0]   col_q;
	logic signed [CARRY_W-1:0] carry_q;
	logic                      hi_q, rnz_q, sign_q, res_neg_q, ovf_q;

	logic                      accept, feed, digest, last_run, last_neg, go_neg;
	logic                      eff_b_neg, hi_hit, rnz_all;
	logic [MAG_W-1:0]          lane_vec;
	logic [COL_W-2:0]          mul_sum;
	logic signed [COL_W-1:0]   col_d, du_col;
	dig_res_t                  du_res;

	assign accept = start && !busy;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (last_run) state_d = go_neg ? ST_NEG : ST_DONE;
			end
			ST_NEG: begin
				if (last_neg) state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = accept ? ST_RUN : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		busy     = 1'b0;
		done     = 1'b0;
		feed     = 1'b0;
		digest   = 1'b0;
		last_run = 1'b0;
		last_neg = 1'b0;
		case (state_q)
			ST_IDLE: begin
			end
			ST_RUN: begin
				busy     = 1'b1;
				feed     = cnt_q < CNT_LAST_RUN;
				digest   = cnt_q != '0;
				last_run = cnt_q == CNT_LAST_RUN;
			end
			ST_NEG: begin
				busy     = 1'b1;
				digest   = 1'b1;
				last_neg = cnt_q == CNT_LAST_NEG;
			end
			ST_DONE: begin
				done = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Effective operation: subtraction flips the second sign, and unlike
	// signs turn an addition into a magnitude subtraction.
	always_comb begin
		eff_b_neg = b_negative ^ (cmd == CMD_SUB);
		if (cmd == CMD_MUL || cmd == CMD_MUL_ALT) begin
			mode_d = MODE_MUL;
		end else if (a_negative == eff_b_neg) begin
			mode_d = MODE_ADD;
		end else begin
			mode_d = MODE_SUB;
		end
	end

	// Lane i holds the second operand's digit k-i while column k is formed.
	assign lane_vec = {lanes_q, b_q[NIB_W-1:0]};

	sbcd_mul_column #(
		.DIGITS(DIGITS)
	) u_mul_column (
		.a_mag      (a_q),
		.lane_digits(lane_vec),
		.col_sum    (mul_sum)
	);

	// Any nonzero product that lands at or above the top column overflows.
	always_comb begin
		hi_hit = 1'b0;
		for (int i = 0; i < DIGITS; i++) begin
			if ((a_q[NIB_W*i +: NIB_W] != '0) && (i + int'(cnt_q) >= DIGITS)) begin
				hi_hit = 1'b1;
			end
		end
		hi_hit = hi_hit && (b_q[NIB_W-1:0] != '0);
	end

	// Column value for the next digit.
	always_comb begin
		case (mode_q)
			MODE_ADD: begin
				col_d = $signed(COL_W'(a_q[NIB_W-1:0])) + $signed(COL_W'(b_q[NIB_W-1:0]));
			end
			MODE_SUB: begin
				col_d = $signed(COL_W'(a_q[NIB_W-1:0])) - $signed(COL_W'(b_q[NIB_W-1:0]));
			end
			MODE_MUL: begin
				col_d = $signed({1'b0, mul_sum});
			end
			default: begin
				col_d = '0;
			end
		endcase
	end

	// The complement pass feeds the negated stored digits through the same unit.
	assign du_col = (state_q == ST_NEG) ? -$signed(COL_W'(res_q[NIB_W-1:0])) : col_q;

	sbcd_digit_unit u_digit_unit (
		.col     (du_col),
		.carry_in(carry_q),
		.res     (du_res)
	);

	assign rnz_all = rnz_q || (du_res.digit != '0);
	assign go_neg  = (mode_q == MODE_SUB) && du_res.carry[CARRY_W-1];

	// Operand, column, carry and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= '0;
		end else if (last_run) begin
			cnt_q <= '0;
		end else if (busy) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_q     <= a_digits[MAG_W-1:0];
			b_q     <= b_digits[MAG_W-1:0];
			lanes_q <= '0;
			carry_q <= '0;
			hi_q    <= 1'b0;
			rnz_q   <= 1'b0;
			mode_q  <= mode_d;
			sign_q  <= (mode_d == MODE_MUL) ? (a_negative ^ b_negative) : a_negative;
		end else begin
			// Step the operands and capture the next column.
			if (feed) begin
				col_q   <= col_d;
				b_q     <= b_q >> NIB_W;
				lanes_q <= lane_vec[MAG_W-NIB_W-1:0];
				if (mode_q != MODE_MUL) begin
					a_q <= a_q >> NIB_W;
				end else begin
					hi_q <= hi_q || hi_hit;
				end
			end
			// Shift each finished digit in from the top. A negative difference
			// restarts the carry for the complement pass.
			if (digest) begin
				res_q   <= {du_res.digit, res_q[MAG_W-1:NIB_W]};
				carry_q <= (last_run && go_neg) ? '0 : du_res.carry;
				rnz_q   <= rnz_all;
			end
			// Capture the sign and overflow at the end of the first pass.
			if (last_run) begin
				if (go_neg) begin
					ovf_q     <= (du_res.carry == CARRY_MINUS2) || !rnz_all;
					res_neg_q <= !sign_q;
				end else begin
					ovf_q     <= (du_res.carry != '0) || ((mode_q == MODE_MUL) && hi_q);
					res_neg_q <= sign_q;
				end
			end
		end
	end

	// Zero is always reported as positive.
	assign result_digits   = FIELD_W'(res_q);
	assign result_negative = res_neg_q && (res_q != '0);
	assign overflow        = ovf_q;

`ifndef SYNTHESIS
	// An accepted transaction keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted transaction did not start work");

	// Work in progress ends only in a result cycle.
	a_busy_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (busy || done))
		else $error("transaction left the sequencer without a result");

	// The complement pass only follows a magnitude subtraction.
	a_neg_is_sub: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NEG) |-> (mode_q == MODE_SUB))
		else $error("complement pass outside a subtraction");

	// A delivered zero never carries a negative sign.
	a_zero_positive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result_negative && (result_digits == '0)))
		else $error("zero result reported as negative");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the signed BCD add, subtract and multiply unit.
`timescale 1ns / 1ps

module tb;
	import sbcd_pkg::*;

	localparam int DIGITS = DIGITS_DEF;
	// Working width of the predictor: room for a full product plus carries.
	localparam int WIDE = 2 * DIGITS + 4;
	localparam int DRAIN_CYCLES = 2 * DIGITS + 4;

	typedef logic [4*WIDE-1:0] dec_wide_t;

	typedef struct packed {
		logic [FIELD_W-1:0] digits;
		logic               negative;
		logic               overflow;
	} signed_bcd_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         cmd;
	logic [FIELD_W-1:0] a_digits;
	logic               a_negative;
	logic [FIELD_W-1:0] b_digits;
	logic               b_negative;
	logic               done;
	logic [FIELD_W-1:0] result_digits;
	logic               result_negative;
	logic               overflow;

	signed_bcd_t pending_results[$];
	int          mismatch_count = 0;

	signed_bcd_add_sub_mul #(
		.DIGITS(DIGITS)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.a_digits       (a_digits),
		.a_negative     (a_negative),
		.b_digits       (b_digits),
		.b_negative     (b_negative),
		.done           (done),
		.result_digits  (result_digits),
		.result_negative(result_negative),
		.overflow       (overflow)
	);

	// Clock with a 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Normalizes an operand into proper decimal digits; wide nibbles carry upward.
	function automatic dec_wide_t widen_bcd(input logic [FIELD_W-1:0] packed_val);
		dec_wide_t   r;
		int unsigned v;
		int unsigned carry;
		r = '0;
		carry = 0;
		for (int i = 0; i < WIDE; i++) begin
			v = carry;
			if (i < DIGITS) begin
				v += packed_val[4*i +: 4];
			end
			r[4*i +: 4] = 4'(v % 10);
			carry = v / 10;
		end
		return r;
	endfunction

	// Decimal sum with a ripple carry.
	function automatic dec_wide_t add_columns(input dec_wide_t x, input dec_wide_t y);
		dec_wide_t   r;
		int unsigned v;
		int unsigned carry;
		r = '0;
		carry = 0;
		for (int i = 0; i < WIDE; i++) begin
			v = x[4*i +: 4] + y[4*i +: 4] + carry;
			r[4*i +: 4] = 4'(v % 10);
			carry = v / 10;
		end
		return r;
	endfunction

	// Decimal difference with a ripple borrow; x must not be below y.
	function automatic dec_wide_t sub_columns(input dec_wide_t x, input dec_wide_t y);
		dec_wide_t   r;
		int unsigned take;
		int unsigned borrow;
		r = '0;
		borrow = 0;
		for (int i = 0; i < WIDE; i++) begin
			take = y[4*i +: 4] + borrow;
			if (x[4*i +: 4] >= take) begin
				r[4*i +: 4] = 4'(x[4*i +: 4] - take);
				borrow = 0;
			end else begin
				r[4*i +: 4] = 4'(x[4*i +: 4] + 10 - take);
				borrow = 1;
			end
		end
		return r;
	endfunction

	// Decimal product: column sums of digit products, then one carry pass.
	function automatic dec_wide_t mul_columns(input dec_wide_t x, input dec_wide_t y);
		dec_wide_t   r;
		int unsigned acc[WIDE];
		int unsigned v;
		int unsigned carry;
		r = '0;
		carry = 0;
		for (int i = 0; i < WIDE; i++) begin
			acc[i] = 0;
		end
		for (int i = 0; i < WIDE; i++) begin
			for (int j = 0; i + j < WIDE; j++) begin
				acc[i+j] += x[4*i +: 4] * y[4*j +: 4];
			end
		end
		for (int i = 0; i < WIDE; i++) begin
			v = acc[i] + carry;
			r[4*i +: 4] = 4'(v % 10);
			carry = v / 10;
		end
		return r;
	endfunction

	// Signed result of one transaction, reduced to DIGITS digits.
	function automatic signed_bcd_t signed_bcd_result(input logic [1:0] op,
			input logic [FIELD_W-1:0] a, input logic an,
			input logic [FIELD_W-1:0] b, input logic bn);
		dec_wide_t   x;
		dec_wide_t   y;
		dec_wide_t   r;
		logic        neg;
		logic        eff_bn;
		signed_bcd_t res;
		x = widen_bcd(a);
		y = widen_bcd(b);
		if (op == CMD_MUL || op == CMD_MUL_ALT) begin
			r = mul_columns(x, y);
			neg = an ^ bn;
		end else begin
			// Subtraction is addition of the operand with its sign flipped.
			eff_bn = (op == CMD_SUB) ? ~bn : bn;
			if (an == eff_bn) begin
				r = add_columns(x, y);
				neg = an;
			end else if (x >= y) begin
				r = sub_columns(x, y);
				neg = an;
			end else begin
				r = sub_columns(y, x);
				neg = eff_bn;
			end
		end
		res.digits = FIELD_W'(r[4*DIGITS-1:0]);
		res.overflow = |r[4*WIDE-1:4*DIGITS];
		res.negative = neg && (res.digits != '0);
		return res;
	endfunction

	// Random valid BCD magnitude with the given number of digits.
	function automatic logic [FIELD_W-1:0] rand_bcd(input int ndig);
		logic [FIELD_W-1:0] r;
		r = '0;
		for (int i = 0; i < DIGITS; i++) begin
			if (i < ndig) begin
				r[4*i +: 4] = 4'($urandom_range(9, 0));
			end
		end
		return r;
	endfunction

	// Digit count, full width at least half the time.
	function automatic int rand_ndig();
		return ($urandom_range(1, 0) == 1) ? DIGITS : int'($urandom_range(DIGITS, 1));
	endfunction

	// Drives one transaction and waits for its acceptance; start is left high.
	task automatic send_item(input logic [1:0] op,
			input logic [FIELD_W-1:0] a, input logic an,
			input logic [FIELD_W-1:0] b, input logic bn);
		cmd <= op;
		a_digits <= a;
		a_negative <= an;
		b_digits <= b;
		b_negative <= bn;
		start <= 1'b1;
		do begin
			@(posedge clk);
		end while (busy);
		pending_results.push_back(signed_bcd_result(op, a, an, b, bn));
	endtask

	// Occasional random gap between transactions.
	task automatic idle_gap();
		if ($urandom_range(99, 0) < 16) begin
			start <= 1'b0;
			repeat ($urandom_range(40, 1)) @(posedge clk);
		end
	endtask

	// Each result is compared with the oldest outstanding expectation.
	always @(posedge clk) begin
		signed_bcd_t exp_res;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: digits %h negative %b overflow %b",
					result_digits, result_negative, overflow);
				mismatch_count++;
			end else begin
				exp_res = pending_results.pop_front();
				if (result_digits !== exp_res.digits) begin
					$error("result_digits: expected %h, got %h", exp_res.digits, result_digits);
					mismatch_count++;
				end
				if (result_negative !== exp_res.negative) begin
					$error("result_negative: expected %b, got %b",
						exp_res.negative, result_negative);
					mismatch_count++;
				end
				if (overflow !== exp_res.overflow) begin
					$error("overflow: expected %b, got %b", exp_res.overflow, overflow);
					mismatch_count++;
				end
			end
		end
	end

	// Boundary values, signs, wraparound, the alternate multiply code and wide nibbles.
	task automatic test_edges();
		logic [FIELD_W-1:0] nines;
		logic [FIELD_W-1:0] half;
		logic [FIELD_W-1:0] e8;
		nines = {DIGITS{4'h9}};
		half = FIELD_W'(64'h5) << (4 * (DIGITS - 1));
		e8 = FIELD_W'(64'h1) << (4 * (DIGITS / 2));
		send_item(CMD_ADD, '0, 1'b0, '0, 1'b0);
		send_item(CMD_ADD, nines, 1'b0, nines, 1'b0);
		send_item(CMD_ADD, nines, 1'b1, nines, 1'b1);
		send_item(CMD_ADD, 64'h1, 1'b0, nines, 1'b0);
		send_item(CMD_SUB, 64'h5, 1'b0, 64'h5, 1'b0);
		send_item(CMD_ADD, 64'h7, 1'b1, 64'h7, 1'b0);
		send_item(CMD_SUB, 64'h3, 1'b0, 64'h8, 1'b0);
		send_item(CMD_SUB, 64'h3, 1'b1, 64'h8, 1'b1);
		send_item(CMD_SUB, '0, 1'b0, nines, 1'b0);
		send_item(CMD_SUB, '0, 1'b1, '0, 1'b0);
		// Sums that wrap exactly to zero keep the overflow flag and a positive sign.
		send_item(CMD_ADD, half, 1'b0, half, 1'b0);
		send_item(CMD_SUB, half, 1'b1, half, 1'b0);
		send_item(CMD_MUL, e8, 1'b1, e8, 1'b0);
		send_item(CMD_MUL, nines, 1'b0, nines, 1'b1);
		send_item(CMD_MUL, 64'h12345, 1'b1, 64'h6789, 1'b0);
		send_item(CMD_MUL, '0, 1'b1, 64'h9, 1'b0);
		send_item(CMD_MUL_ALT, 64'h25, 1'b1, 64'h4, 1'b1);
		send_item(CMD_MUL_ALT, nines, 1'b0, nines, 1'b0);
		// Nibbles above nine count with their binary value at their decimal weight.
		send_item(CMD_ADD, '1, 1'b0, '1, 1'b0);
		send_item(CMD_SUB, 64'hA, 1'b0, 64'h10, 1'b0);
		send_item(CMD_SUB, 64'hF, 1'b1, 64'hFFFF, 1'b0);
		send_item(CMD_MUL, '1, 1'b0, '1, 1'b1);
		send_item(CMD_ADD, 64'hA0B0_C0D0_E0F0_0000, 1'b1, 64'h9, 1'b0);
		idle_gap();
	endtask

	// Random add and subtract, with many operand pairs of equal or near magnitude.
	task automatic test_add_sub(input int count);
		logic [1:0]         op;
		logic [FIELD_W-1:0] a;
		logic [FIELD_W-1:0] b;
		int                 low;
		for (int n = 0; n < count; n++) begin
			op = ($urandom_range(1, 0) == 1) ? CMD_SUB : CMD_ADD;
			a = rand_bcd(rand_ndig());
			case ($urandom_range(3, 0))
				0: begin
					b = a;
				end
				1: begin
					low = $urandom_range(DIGITS, 1);
					b = a;
					for (int i = 0; i < low; i++) begin
						b[4*i +: 4] = 4'($urandom_range(9, 0));
					end
				end
				default: begin
					b = rand_bcd(rand_ndig());
				end
			endcase
			send_item(op, a, 1'($urandom), b, 1'($urandom));
			idle_gap();
		end
	endtask

	// Random products over both multiply codes and all digit counts.
	task automatic test_multiply(input int count);
		logic [1:0] op;
		for (int n = 0; n < count; n++) begin
			op = ($urandom_range(7, 0) == 0) ? CMD_MUL_ALT : CMD_MUL;
			send_item(op, rand_bcd(int'($urandom_range(DIGITS, 1))), 1'($urandom),
				rand_bcd(int'($urandom_range(DIGITS, 1))), 1'($urandom));
			idle_gap();
		end
	endtask

	// Raw random operands and commands, including nibbles that are not decimal.
	task automatic test_raw_operands(input int count);
		for (int n = 0; n < count; n++) begin
			send_item(2'($urandom), {$urandom, $urandom}, 1'($urandom),
				{$urandom, $urandom}, 1'($urandom));
			idle_gap();
		end
	endtask

	// A long stretch of valid transactions with no gaps at all.
	task automatic test_back_to_back(input int count);
		logic [1:0] op;
		for (int n = 0; n < count; n++) begin
			op = 2'($urandom);
			send_item(op, rand_bcd(rand_ndig()), 1'($urandom),
				rand_bcd(rand_ndig()), 1'($urandom));
		end
	endtask

	// Reset, the test sequence, then drain and the verdict.
	initial begin
		int guard;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_ADD;
		a_digits = '0;
		a_negative = 1'b0;
		b_digits = '0;
		b_negative = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edges();
		test_add_sub(450);
		test_multiply(350);
		test_raw_operands(200);
		test_back_to_back(230);

		start <= 1'b0;
		guard = 0;
		while (pending_results.size() != 0 && guard < 8 * DRAIN_CYCLES) begin
			@(posedge clk);
			guard++;
		end
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			mismatch_count++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
